>>> sv/rhs_pkg.sv
// shared constants and types for the rgb to hsv converter
package rhs_pkg;

  // hue angles in 1/64 degree
  localparam logic signed [25:0] DEG60_Q6  = 26'sd3840;
  localparam logic [21:0]        DEG180_Q6 = 22'd11520;
  localparam logic signed [15:0] HUE_OFS   = 16'sd11520;
  localparam logic signed [15:0] BUMP_Q6   = 16'sd64;

  // value thresholds as exact tests on the max byte (10*mx > k*255)
  localparam logic [11:0] V06_LIM = 12'd1530;
  localparam logic [11:0] V03_LIM = 12'd765;
  localparam logic [11:0] V02_LIM = 12'd510;

  // saturation thresholds in percent
  localparam logic [14:0] PCT100 = 15'd100;
  localparam logic [14:0] PCT99  = 15'd99;
  localparam logic [14:0] PCT98  = 15'd98;

  // one quotient bit per cell
  localparam int NUM_CELLS = 17;
  localparam int REM_W     = 26;
  localparam int QUO_W     = 17;

  // data handed from cell to cell
  typedef struct packed {
    logic [REM_W-1:0] hrem;
    logic [REM_W-1:0] hdiv;
    logic [REM_W-1:0] srem;
    logic [REM_W-1:0] sdiv;
    logic [QUO_W-1:0] hq;
    logic [QUO_W-1:0] sq;
    logic [7:0]       mx;
    logic             bump;
    logic             gray;
    logic             black;
  } rhs_div_t;

endpackage

>>> sv/rhs_pix_if.sv
// pixel channel: one rgb beat
interface rhs_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

>>> sv/rhs_hsv_if.sv
// result channel: one hsv beat
interface rhs_hsv_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] hue_q6;
  logic [16:0]        saturation_q16;
  logic [7:0]         value_level;

  modport source (output valid, output hue_q6, output saturation_q16, output value_level,
                  input ready);
  modport sink   (input valid, input hue_q6, input saturation_q16, input value_level,
                  output ready);
endinterface

>>> sv/rhs_front.sv
// front end: max/min, sector numerator, wrap and divider operands
module rhs_front import rhs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_ready,
  output rhs_div_t   out_data
);

  // stage a registers
  logic                    a_valid_r, a_valid_nxt;
  logic [7:0]              a_mx_r, a_mx_nxt;
  logic [7:0]              a_del_r, a_del_nxt;
  logic signed [REM_W-1:0] a_num_r, a_num_nxt;
  logic [21:0]             a_d180_r, a_d180_nxt;
  logic                    a_bump_r, a_bump_nxt;

  // stage b registers
  logic     b_valid_r, b_valid_nxt;
  rhs_div_t b_data_r, b_data_nxt;

  logic a_adv, b_adv;

  // stage a comb
  logic [7:0]              mx, mn, del;
  logic signed [8:0]       d_gb, d_br, d_rg;
  logic signed [REM_W-1:0] del_s;
  logic                    hue_zero;
  logic [14:0]             del_pct, mx_pct98, mx_pct99;
  logic [11:0]             mx10;
  logic                    s98, s99, s100, v06, v03, v02;

  // stage b comb
  logic signed [REM_W-1:0] d180_s, num_w, pos;

  assign b_adv    = !b_valid_r || out_ready;
  assign a_adv    = !a_valid_r || b_adv;
  assign in_ready = a_adv;

  // extremes and sector numerator
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    del   = mx - mn;
    del_s = $signed({18'd0, del});
    d_gb  = $signed({1'b0, green}) - $signed({1'b0, blue});
    d_br  = $signed({1'b0, blue}) - $signed({1'b0, red});
    d_rg  = $signed({1'b0, red}) - $signed({1'b0, green});
    hue_zero = 1'b0;
    if (red >= mx) begin
      a_num_nxt = DEG60_Q6 * REM_W'(d_gb);
      hue_zero  = (green == blue);
    end else if (green >= mx) begin
      a_num_nxt = DEG60_Q6 * REM_W'(d_br) + ((DEG60_Q6 * del_s) <<< 1);
    end else begin
      a_num_nxt = DEG60_Q6 * REM_W'(d_rg) + ((DEG60_Q6 * del_s) <<< 2);
    end
    if (del == 8'd0) hue_zero = 1'b1;
    a_d180_nxt = DEG180_Q6 * {14'd0, del};
    a_mx_nxt   = mx;
    a_del_nxt  = del;
  end

  // one degree bump, exact integer tests
  always_comb begin
    del_pct  = PCT100 * {7'd0, del};
    mx_pct98 = PCT98 * {7'd0, mx};
    mx_pct99 = PCT99 * {7'd0, mx};
    mx10     = 12'd10 * {4'd0, mx};
    s98  = del_pct >= mx_pct98;
    s99  = del_pct >= mx_pct99;
    s100 = del == mx;
    v06  = mx10 > V06_LIM;
    v03  = mx10 > V03_LIM;
    v02  = mx10 > V02_LIM;
    a_bump_nxt = (hue_zero && s98 && v06) || (s99 && v03) || (s100 && v02);
  end

  // wrap into the signed range and build divider operands
  always_comb begin
    d180_s = $signed({4'd0, a_d180_r});
    if (a_num_r >= d180_s) num_w = a_num_r - (d180_s <<< 1);
    else                   num_w = a_num_r;
    pos = num_w + d180_s;
    b_data_nxt.hrem  = REM_W'((pos <<< 1) + $signed({18'd0, a_del_r}));
    b_data_nxt.hdiv  = {1'b0, a_del_r, 17'd0};
    b_data_nxt.srem  = {1'b0, a_del_r, 9'd0, a_mx_r};
    b_data_nxt.sdiv  = {1'b0, a_mx_r, 17'd0};
    b_data_nxt.hq    = '0;
    b_data_nxt.sq    = '0;
    b_data_nxt.mx    = a_mx_r;
    b_data_nxt.bump  = a_bump_r;
    b_data_nxt.gray  = (a_del_r == 8'd0);
    b_data_nxt.black = (a_mx_r == 8'd0);
  end

  assign a_valid_nxt = a_adv ? in_valid : a_valid_r;
  assign b_valid_nxt = b_adv ? a_valid_r : b_valid_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_mx_r   <= a_mx_nxt;
      a_del_r  <= a_del_nxt;
      a_num_r  <= a_num_nxt;
      a_d180_r <= a_d180_nxt;
      a_bump_r <= a_bump_nxt;
    end
    if (b_adv) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

>>> sv/rhs_div_cell.sv
// divider cell: one quotient bit for hue and saturation, then hand on
module rhs_div_cell import rhs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rhs_div_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rhs_div_t out_data
);

  logic     valid_r, valid_nxt;
  rhs_div_t data_r, data_nxt;
  logic     adv, h_ge, s_ge;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;

  // compare, subtract, shift divisor down by one
  always_comb begin
    h_ge = in_data.hrem >= in_data.hdiv;
    s_ge = in_data.srem >= in_data.sdiv;
    data_nxt      = in_data;
    data_nxt.hrem = h_ge ? in_data.hrem - in_data.hdiv : in_data.hrem;
    data_nxt.srem = s_ge ? in_data.srem - in_data.sdiv : in_data.srem;
    data_nxt.hdiv = in_data.hdiv >> 1;
    data_nxt.sdiv = in_data.sdiv >> 1;
    data_nxt.hq   = {in_data.hq[QUO_W-2:0], h_ge};
    data_nxt.sq   = {in_data.sq[QUO_W-2:0], s_ge};
  end

  assign valid_nxt = adv ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> sv/rhs_back.sv
// back end: hue offset, bump, special cases and output register
module rhs_back import rhs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rhs_div_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] hue,
  output logic [16:0]        sat,
  output logic [7:0]         val
);

  logic               valid_r, valid_nxt;
  logic signed [14:0] hue_r, hue_nxt;
  logic [16:0]        sat_r, sat_nxt;
  logic [7:0]         val_r;
  logic signed [15:0] hq_s, base, hue16;
  logic               adv;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;

  // shift hue back to signed, add bump, clear gray and black cases
  always_comb begin
    hq_s  = $signed({1'b0, in_data.hq[14:0]}) - HUE_OFS;
    base  = in_data.gray ? 16'sd0 : hq_s;
    hue16 = base + (in_data.bump ? BUMP_Q6 : 16'sd0);
    hue_nxt = hue16[14:0];
    sat_nxt = in_data.black ? 17'd0 : in_data.sq;
  end

  assign valid_nxt = adv ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= in_data.mx;
    end
  end

  assign out_valid = valid_r;
  assign hue       = hue_r;
  assign sat       = sat_r;
  assign val       = val_r;

endmodule

>>> sv/rgb_to_hsv_signed_hue_core.sv
// top level: rgb pixel to signed hue, saturation and value
//
//   channel   dir  beat contents
//   in_pix    in   red_in, green_in, blue_in (8 bits each)
//   out_hsv   out  hue_q6 (15 signed), saturation_q16 (17), value_level (8)
//
// one pixel per clock while out_hsv.ready holds; the pipe is two front stages,
// a row of 17 divider cells (one quotient bit each), one output register.
// every stage has its own valid bit and takes a new beat whenever it is
// empty or its neighbor takes its beat, so bubbles close up under stall.
// rst_n is synchronous and clears only the valid bits.
module rgb_to_hsv_signed_hue_core import rhs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rhs_pix_if.sink   in_pix,
  rhs_hsv_if.source out_hsv
);

  rhs_div_t cdata  [0:NUM_CELLS];
  logic     cvalid [0:NUM_CELLS];
  logic     cready [0:NUM_CELLS];

  // operand preparation
  rhs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .red       (in_pix.red_in),
    .green     (in_pix.green_in),
    .blue      (in_pix.blue_in),
    .out_valid (cvalid[0]),
    .out_ready (cready[0]),
    .out_data  (cdata[0])
  );

  // row of divider cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rhs_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cvalid[i]),
      .in_ready  (cready[i]),
      .in_data   (cdata[i]),
      .out_valid (cvalid[i+1]),
      .out_ready (cready[i+1]),
      .out_data  (cdata[i+1])
    );
  end

  // result formatting and output register
  rhs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cvalid[NUM_CELLS]),
    .in_ready  (cready[NUM_CELLS]),
    .in_data   (cdata[NUM_CELLS]),
    .out_valid (out_hsv.valid),
    .out_ready (out_hsv.ready),
    .hue       (out_hsv.hue_q6),
    .sat       (out_hsv.saturation_q16),
    .val       (out_hsv.value_level)
  );

endmodule
